@@ design/nns_pkg.sv @@
// Shared types and constants for the nearest-neighbor scaler.
package nns_pkg;

  localparam int DIM_W     = 16;
  localparam int SRC_W_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 3'd3;

  typedef enum logic [2:0] {
    ST_ACCEPT     = 3'd0,
    ST_REFUSE     = 3'd1,
    ST_PIXEL      = 3'd2,
    ST_NOT_READY  = 3'd3,
    ST_FRAME_DONE = 3'd4
  } nns_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIVIDE,
    S_RESP
  } nns_state_t;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } nns_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            row_end;
    logic            frame_end;
  } nns_out_t;

endpackage

@@ design/nearest_neighbor_scaler.sv @@
// Top level of the nearest-neighbor scaler: line buffer, counters and response path.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------
//   in      | in_valid / in_ready     | in_data  (nns_in_t)
//   out     | out_valid / out_ready   | out_data (nns_out_t)
//   cfg     | cfg_we, no wait         | cfg_index, cfg_data
//
// Each beat: the accept cycle updates the counters and starts the line-buffer write or
// read, then the response state loads the output register once that register is free.
// A register write reruns both scale-factor divisions with in_ready low.
// Reset leaves all dimensions at 1 and the frame restarted; the line buffer is not cleared.
// A stalled output holds the next item in the response state until out_ready.
module nearest_neighbor_scaler
  import nns_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nns_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nns_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  nns_state_t state_r, state_nxt;

  logic [SRC_W_W-1:0] src_w_r, src_w_nxt;
  logic [DIM_W-1:0]   src_h_r, src_h_nxt;
  logic [DIM_W-1:0]   tgt_w_r, tgt_w_nxt;
  logic [DIM_W-1:0]   tgt_h_r, tgt_h_nxt;

  logic               row_ready_r, row_ready_nxt;
  logic [DIM_W-1:0]   load_row_r, load_row_nxt;
  logic [SRC_W_W-1:0] load_col_r, load_col_nxt;
  logic [DIM_W-1:0]   out_row_r, out_row_nxt;
  logic [DIM_W-1:0]   out_col_r, out_col_nxt;
  logic [DIM_W-1:0]   needed_row_r, needed_row_nxt;
  logic [DIM_W-1:0]   row_rem_r, row_rem_nxt;
  logic [SRC_W_W-1:0] src_col_r, src_col_nxt;
  logic [DIM_W-1:0]   col_rem_r, col_rem_nxt;

  logic [DIM_W-1:0]   col_quo_r, col_quo_nxt;
  logic [DIM_W-1:0]   col_mod_r, col_mod_nxt;
  logic [DIM_W-1:0]   row_quo_r, row_quo_nxt;
  logic [DIM_W-1:0]   row_mod_r, row_mod_nxt;

  logic               out_valid_r, out_valid_nxt;
  nns_out_t           out_data_r, out_data_nxt;
  nns_status_t        res_status_r, res_status_nxt;
  logic               res_rend_r, res_rend_nxt;
  logic               res_fend_r, res_fend_nxt;

  logic [PIX_W-1:0]   lbuf_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   mem_q_r;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;

  logic [SRC_W_W-1:0] sw_nz, sw_e;
  logic [DIM_W-1:0]   sh_e, tw_e, th_e;
  logic               cfg_hit, accept, done, store, drop, rend, fend, out_free;
  logic [DIM_W:0]     col_sum, row_sum;
  logic [DIM_W:0]     src_step, row_step;

  logic               div_start, col_busy, row_busy;
  logic [DIM_W-1:0]   col_q, col_r, row_q, row_r;

  nns_div u_col_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (DIM_W'(sw_e)),
    .divisor   (tw_e),
    .busy      (col_busy),
    .quotient  (col_q),
    .remainder (col_r)
  );

  nns_div u_row_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (sh_e),
    .divisor   (th_e),
    .busy      (row_busy),
    .quotient  (row_q),
    .remainder (row_r)
  );

  always_comb begin
    sw_nz = (src_w_r == '0) ? SRC_W_W'(1) : src_w_r;
    if ({4'b0, sw_nz} > 17'(MAX_WIDTH)) begin
      sw_e = SRC_W_W'(MAX_WIDTH);
    end else begin
      sw_e = sw_nz;
    end
    sh_e = (src_h_r == '0) ? DIM_W'(1) : src_h_r;
    tw_e = (tgt_w_r == '0) ? DIM_W'(1) : tgt_w_r;
    th_e = (tgt_h_r == '0) ? DIM_W'(1) : tgt_h_r;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign div_start = (state_r == S_SETUP);

  assign done  = (out_row_r >= th_e);
  assign store = !done && (load_row_r == needed_row_r) && !row_ready_r;
  assign drop  = done ? (load_row_r < sh_e) : (load_row_r < needed_row_r);
  assign rend  = ({1'b0, out_col_r} + 17'd1) >= {1'b0, tw_e};
  assign fend  = rend && (({1'b0, out_row_r} + 17'd1) >= {1'b0, th_e});

  assign col_sum  = {1'b0, col_rem_r} + {1'b0, col_mod_r};
  assign row_sum  = {1'b0, row_rem_r} + {1'b0, row_mod_r};
  assign src_step = {4'b0, src_col_r} + {1'b0, col_quo_r};
  assign row_step = {1'b0, needed_row_r} + {1'b0, row_quo_r};

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_index)
      REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_TGT_WIDTH, REG_TGT_HEIGHT: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    src_w_nxt      = src_w_r;
    src_h_nxt      = src_h_r;
    tgt_w_nxt      = tgt_w_r;
    tgt_h_nxt      = tgt_h_r;
    row_ready_nxt  = row_ready_r;
    load_row_nxt   = load_row_r;
    load_col_nxt   = load_col_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    needed_row_nxt = needed_row_r;
    row_rem_nxt    = row_rem_r;
    src_col_nxt    = src_col_r;
    col_rem_nxt    = col_rem_r;
    col_quo_nxt    = col_quo_r;
    col_mod_nxt    = col_mod_r;
    row_quo_nxt    = row_quo_r;
    row_mod_nxt    = row_mod_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    res_status_nxt = res_status_r;
    res_rend_nxt   = res_rend_r;
    res_fend_nxt   = res_fend_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wa         = AW'(load_col_r);
    mem_ra         = AW'(src_col_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_rend_nxt = 1'b0;
          res_fend_nxt = 1'b0;
          state_nxt    = S_RESP;
          if (in_data.mode == MODE_PUSH) begin
            if (store || drop) begin
              mem_we = store;
              if (({1'b0, load_col_r} + 14'd1) >= {1'b0, sw_e}) begin
                load_col_nxt = '0;
                load_row_nxt = load_row_r + DIM_W'(1);
                if (store) begin
                  row_ready_nxt = 1'b1;
                end
              end else begin
                load_col_nxt = load_col_r + SRC_W_W'(1);
              end
              res_status_nxt = ST_ACCEPT;
            end else begin
              res_status_nxt = ST_REFUSE;
            end
          end else if (done) begin
            res_status_nxt = ST_FRAME_DONE;
          end else if (!row_ready_r) begin
            res_status_nxt = ST_NOT_READY;
          end else begin
            res_status_nxt = ST_PIXEL;
            res_rend_nxt   = rend;
            res_fend_nxt   = fend;
            mem_re         = 1'b1;
            if (!rend) begin
              out_col_nxt = out_col_r + DIM_W'(1);
              if (col_sum >= {1'b0, tw_e}) begin
                col_rem_nxt = DIM_W'(col_sum - {1'b0, tw_e});
                src_col_nxt = SRC_W_W'(src_step + 17'd1);
              end else begin
                col_rem_nxt = DIM_W'(col_sum);
                src_col_nxt = SRC_W_W'(src_step);
              end
            end else begin
              out_col_nxt = '0;
              src_col_nxt = '0;
              col_rem_nxt = '0;
              out_row_nxt = out_row_r + DIM_W'(1);
              if (row_sum >= {1'b0, th_e}) begin
                row_rem_nxt    = DIM_W'(row_sum - {1'b0, th_e});
                needed_row_nxt = DIM_W'(row_step + 17'd1);
              end else begin
                row_rem_nxt    = DIM_W'(row_sum);
                needed_row_nxt = DIM_W'(row_step);
              end
              if (needed_row_nxt != needed_row_r) begin
                row_ready_nxt = 1'b0;
              end
            end
          end
        end
      end
      S_SETUP: begin
        state_nxt = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (!col_busy && !row_busy) begin
          col_quo_nxt = col_q;
          col_mod_nxt = col_r;
          row_quo_nxt = row_q;
          row_mod_nxt = row_r;
          state_nxt   = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = res_status_r;
          out_data_nxt.row_end   = res_rend_r;
          out_data_nxt.frame_end = res_fend_r;
          if (res_status_r == ST_PIXEL) begin
            {out_data_nxt.out_red, out_data_nxt.out_green, out_data_nxt.out_blue} = mem_q_r;
          end else begin
            out_data_nxt.out_red   = '0;
            out_data_nxt.out_green = '0;
            out_data_nxt.out_blue  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_hit) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_nxt = cfg_data[SRC_W_W-1:0];
        REG_SRC_HEIGHT: src_h_nxt = cfg_data[DIM_W-1:0];
        REG_TGT_WIDTH:  tgt_w_nxt = cfg_data[DIM_W-1:0];
        REG_TGT_HEIGHT: tgt_h_nxt = cfg_data[DIM_W-1:0];
        default:        src_w_nxt = src_w_r;
      endcase
      row_ready_nxt  = 1'b0;
      load_row_nxt   = '0;
      load_col_nxt   = '0;
      out_row_nxt    = '0;
      out_col_nxt    = '0;
      needed_row_nxt = '0;
      row_rem_nxt    = '0;
      src_col_nxt    = '0;
      col_rem_nxt    = '0;
      state_nxt      = S_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      src_w_r      <= SRC_W_W'(1);
      src_h_r      <= DIM_W'(1);
      tgt_w_r      <= DIM_W'(1);
      tgt_h_r      <= DIM_W'(1);
      row_ready_r  <= 1'b0;
      load_row_r   <= '0;
      load_col_r   <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      needed_row_r <= '0;
      row_rem_r    <= '0;
      src_col_r    <= '0;
      col_rem_r    <= '0;
      col_quo_r    <= DIM_W'(1);
      col_mod_r    <= '0;
      row_quo_r    <= DIM_W'(1);
      row_mod_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      src_w_r      <= src_w_nxt;
      src_h_r      <= src_h_nxt;
      tgt_w_r      <= tgt_w_nxt;
      tgt_h_r      <= tgt_h_nxt;
      row_ready_r  <= row_ready_nxt;
      load_row_r   <= load_row_nxt;
      load_col_r   <= load_col_nxt;
      out_row_r    <= out_row_nxt;
      out_col_r    <= out_col_nxt;
      needed_row_r <= needed_row_nxt;
      row_rem_r    <= row_rem_nxt;
      src_col_r    <= src_col_nxt;
      col_rem_r    <= col_rem_nxt;
      col_quo_r    <= col_quo_nxt;
      col_mod_r    <= col_mod_nxt;
      row_quo_r    <= row_quo_nxt;
      row_mod_r    <= row_mod_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    res_status_r <= res_status_nxt;
    res_rend_r   <= res_rend_nxt;
    res_fend_r   <= res_fend_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lbuf_mem[mem_wa] <= {in_data.red, in_data.green, in_data.blue};
    end
    if (mem_re) begin
      mem_q_r <= lbuf_mem[mem_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/nns_div.sv @@
// Restoring divider, one quotient bit per cycle.
module nns_div
  import nns_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIM_W-1:0] dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             busy,
  output logic [DIM_W-1:0] quotient,
  output logic [DIM_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIM_W-1:0] rem_r, rem_nxt;
  logic [DIM_W-1:0] quo_r, quo_nxt;
  logic [DIM_W-1:0] dsr_r, dsr_nxt;
  logic [DIM_W:0]   shifted;
  logic [DIM_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DIM_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIM_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = diff[DIM_W-1:0];
        quo_nxt = {quo_r[DIM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIM_W-1:0];
        quo_nxt = {quo_r[DIM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
